[sv/world_to_screen_projection_core_macros.svh]
// assertion macros for the world to screen projection core
// used by the top level; expects clk and arst_n in scope
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define W2S_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define W2S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/w2s_pkg.sv]
// shared types and constants for the world to screen projection core
// no dependencies
package w2s_pkg;

	// default fixed-point format
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_COORD_BITS = 32;

	// matrix entry word width
	localparam int MAT_W = 32;

	// ndc magnitude cap is 2^CAP_LOG, quotient keeps CAP_LOG+1 bits
	localparam int CAP_LOG = 40;
	localparam int QB      = CAP_LOG + 1;
	localparam int NDC_W   = QB + 1;

	// viewport size registers
	localparam int SIZE_W = 15;
	localparam int HALF_W = SIZE_W - 1;
	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(768);

	// register bus
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_X_LO  = 3'd0,
		REG_X_HI  = 3'd1,
		REG_Y_LO  = 3'd2,
		REG_Y_HI  = 3'd3,
		REG_W_LO  = 3'd4,
		REG_W_HI  = 3'd5,
		REG_WIDTH = 3'd6,
		REG_HEIGHT= 3'd7
	} reg_idx_t;

	// control that travels with each request
	typedef struct packed {
		logic vld;
		logic vis;
	} ctl_t;

endpackage

[sv/w2s_dot.sv]
// one matrix row times the point: three products then a sum, two stages
// depends on w2s_pkg
module w2s_dot #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 32,
	parameter int CLIP_W     = 50
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  w2s_pkg::ctl_t                 in_ctl,
	input  logic signed [COORD_BITS-1:0]  in_x,
	input  logic signed [COORD_BITS-1:0]  in_y,
	input  logic signed [COORD_BITS-1:0]  in_z,
	input  logic [63:0]                   row_lo,
	input  logic [63:0]                   row_hi,
	output w2s_pkg::ctl_t                 out_ctl,
	output logic signed [CLIP_W-1:0]      out_clip
);
	import w2s_pkg::*;

	localparam int PW = COORD_BITS + MAT_W;
	localparam int SW = PW - FRAC_BITS;

	logic signed [MAT_W-1:0] ma, mb, mc, md;
	logic signed [PW-1:0]    px_s1, py_s1, pz_s1;
	logic signed [MAT_W-1:0] md_s1;
	ctl_t                    ctl_s1, ctl_s2;
	logic signed [SW-1:0]    fx, fy, fz;
	logic signed [CLIP_W-1:0] clip_s2;

	// unpack row words
	assign ma = signed'(row_lo[31:0]);
	assign mb = signed'(row_lo[63:32]);
	assign mc = signed'(row_hi[31:0]);
	assign md = signed'(row_hi[63:32]);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// exact products
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= PW'(in_x) * PW'(ma);
			py_s1 <= PW'(in_y) * PW'(mb);
			pz_s1 <= PW'(in_z) * PW'(mc);
			md_s1 <= md;
		end
	end

	// floor to frac bits by dropping low bits
	assign fx = $signed(px_s1[PW-1:FRAC_BITS]);
	assign fy = $signed(py_s1[PW-1:FRAC_BITS]);
	assign fz = $signed(pz_s1[PW-1:FRAC_BITS]);

	// row sum with translation
	always_ff @(posedge clk) begin
		if (en) begin
			clip_s2 <= CLIP_W'(fx) + CLIP_W'(fy) + CLIP_W'(fz) + CLIP_W'(md_s1);
		end
	end

	assign out_ctl  = ctl_s2;
	assign out_clip = clip_s2;

endmodule

[sv/w2s_div.sv]
// pipelined restoring divider, one quotient bit per stage, magnitude capped
// depends on w2s_pkg
module w2s_div #(
	parameter int FRAC_BITS = 16,
	parameter int CLIP_W    = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  w2s_pkg::ctl_t                     in_ctl,
	input  logic                              in_neg,
	input  logic [CLIP_W-1:0]                 in_num,
	input  logic [CLIP_W-1:0]                 in_den,
	output w2s_pkg::ctl_t                     out_ctl,
	output logic signed [w2s_pkg::NDC_W-1:0]  out_ndc
);
	import w2s_pkg::*;

	localparam int NW = CLIP_W + FRAC_BITS;
	localparam logic [QB-1:0] CAP_V = {1'b1, {CAP_LOG{1'b0}}};

	logic [NW-1:0]     numw, sh;
	logic              ovf;
	ctl_t              ctl_s  [0:QB];
	logic [CLIP_W-1:0] rem_s  [0:QB];
	logic [CLIP_W-1:0] den_s  [0:QB];
	logic [QB-1:0]     quo_s  [0:QB];
	logic [QB-1:0]     nlo_s  [0:QB];
	logic              neg_s  [0:QB];
	logic              ovf_s  [0:QB];
	ctl_t              ctl_last_s;
	logic signed [NDC_W-1:0] ndc_last_s;
	logic [QB-1:0]     mag;

	// scaled numerator, overflow when quotient needs more than QB bits
	assign numw = {in_num, {FRAC_BITS{1'b0}}};
	assign sh   = numw >> QB;
	assign ovf  = sh >= NW'(in_den);

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sh[CLIP_W-1:0];
			den_s[0] <= in_den;
			quo_s[0] <= '0;
			nlo_s[0] <= numw[QB-1:0];
			neg_s[0] <= in_neg;
			ovf_s[0] <= ovf;
		end
	end

	// one compare and subtract per stage
	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [CLIP_W:0] t;
		logic            ge;

		assign t  = {rem_s[k], nlo_s[k][QB-1-k]};
		assign ge = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? CLIP_W'(t - {1'b0, den_s[k]}) : t[CLIP_W-1:0];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				nlo_s[k+1] <= nlo_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// cap and sign
	assign mag = (ovf_s[QB] || (quo_s[QB] > CAP_V)) ? CAP_V : quo_s[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_last_s <= '0;
		end else if (en) begin
			ctl_last_s <= ctl_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ndc_last_s <= neg_s[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign out_ctl = ctl_last_s;
	assign out_ndc = ndc_last_s;

endmodule

[sv/w2s_view.sv]
// viewport map: half size times ndc, offset, saturate; two stages
// depends on w2s_pkg
module w2s_view #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  w2s_pkg::ctl_t                     in_ctl,
	input  logic signed [w2s_pkg::NDC_W-1:0]  in_ndc_x,
	input  logic signed [w2s_pkg::NDC_W-1:0]  in_ndc_y,
	input  logic [w2s_pkg::HALF_W-1:0]        half_w,
	input  logic [w2s_pkg::HALF_W-1:0]        half_h,
	output w2s_pkg::ctl_t                     out_ctl,
	output logic signed [COORD_BITS-1:0]      out_x,
	output logic signed [COORD_BITS-1:0]      out_y
);
	import w2s_pkg::*;

	localparam int MW = HALF_W + 1 + NDC_W;
	localparam int SUMW = MW + 1;
	localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] SMIN = SUMW'(-(64'sd1 <<< (COORD_BITS - 1)));

	ctl_t                   ctl_s1, ctl_s2;
	logic signed [MW-1:0]   px_s1, py_s1;
	logic signed [SUMW-1:0] off_w, off_h, sx, sy;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] c;
		c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
		return c[COORD_BITS-1:0];
	endfunction

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// half size products
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= MW'($signed({1'b0, half_w})) * MW'(in_ndc_x);
			py_s1 <= MW'($signed({1'b0, half_h})) * MW'(in_ndc_y);
		end
	end

	// offsets and saturation
	assign off_w = SUMW'($signed({1'b0, half_w, {FRAC_BITS{1'b0}}}));
	assign off_h = SUMW'($signed({1'b0, half_h, {FRAC_BITS{1'b0}}}));
	assign sx    = SUMW'(px_s1) + off_w;
	assign sy    = off_h - SUMW'(py_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= ctl_s1.vis ? sat(sx) : '0;
			y_s2 <= ctl_s1.vis ? sat(sy) : '0;
		end
	end

	assign out_ctl = ctl_s2;
	assign out_x   = x_s2;
	assign out_y   = y_s2;

endmodule

[sv/world_to_screen_projection_core.sv]
// world to screen projection core: matrix rows, divide by w, viewport
// depends on w2s_pkg, w2s_dot, w2s_div, w2s_view and the macros header
//
//  channel | handshake                   | payload
//  point   | point_valid / point_stall   | world_x, world_y, world_z
//  screen  | screen_valid / screen_stall | visible, screen_x, screen_y
//  config  | psel, penable, pwrite       | paddr, pwdata, prdata
//
// one request per cycle while no result is held under screen_stall;
// the divider resolves one quotient bit per stage
// the whole pipeline holds while a result waits under screen_stall
// reset clears valid bits and loads the register defaults; no clearing pass
`include "world_to_screen_projection_core_macros.svh"

module world_to_screen_projection_core #(
	parameter int FRAC_BITS  = w2s_pkg::DEF_FRAC_BITS,
	parameter int COORD_BITS = w2s_pkg::DEF_COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [w2s_pkg::ADDR_W-1:0]         paddr,
	input  logic [w2s_pkg::DATA_W-1:0]         pwdata,
	output logic [w2s_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  logic                               point_valid,
	output logic                               point_stall,
	input  logic signed [COORD_BITS-1:0]       world_x,
	input  logic signed [COORD_BITS-1:0]       world_y,
	input  logic signed [COORD_BITS-1:0]       world_z,
	output logic                               screen_valid,
	input  logic                               screen_stall,
	output logic                               visible,
	output logic signed [COORD_BITS-1:0]       screen_x,
	output logic signed [COORD_BITS-1:0]       screen_y
);
	import w2s_pkg::*;

	localparam int CLIP_W = COORD_BITS + MAT_W - FRAC_BITS + 2;
	localparam longint WMIN = ((64'sd1 <<< FRAC_BITS) + 64'sd9) / 64'sd10;
	localparam logic signed [CLIP_W-1:0] WMIN_C = CLIP_W'(WMIN);
	localparam logic signed [NDC_W-1:0] CAP_P = NDC_W'(64'sd1 <<< CAP_LOG);

	logic [DATA_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q, wlo_q, whi_q;
	logic [SIZE_W-1:0] width_q, height_q;
	reg_idx_t          idx;
	logic              en;

	ctl_t                     ctl_s1, ctl_s4, ctl_d, ctl_v, ctl_nc;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic signed [CLIP_W-1:0] cx, cy, cw;
	logic [CLIP_W-1:0]        nx_s4, ny_s4, den_s4;
	logic                     negx_s4, negy_s4;
	logic signed [NDC_W-1:0]  ndcx, ndcy;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlo_q    <= '0;
			xhi_q    <= '0;
			ylo_q    <= '0;
			yhi_q    <= '0;
			wlo_q    <= '0;
			whi_q    <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_X_LO:   xlo_q    <= pwdata;
				REG_X_HI:   xhi_q    <= pwdata;
				REG_Y_LO:   ylo_q    <= pwdata;
				REG_Y_HI:   yhi_q    <= pwdata;
				REG_W_LO:   wlo_q    <= pwdata;
				REG_W_HI:   whi_q    <= pwdata;
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			REG_X_LO:   prdata = xlo_q;
			REG_X_HI:   prdata = xhi_q;
			REG_Y_LO:   prdata = ylo_q;
			REG_Y_HI:   prdata = yhi_q;
			REG_W_LO:   prdata = wlo_q;
			REG_W_HI:   prdata = whi_q;
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// pipeline moves unless a finished result is held
	assign en          = !(screen_valid && screen_stall);
	assign point_stall = !en;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: point_valid, vis: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= world_x;
			y_s1 <= world_y;
			z_s1 <= world_z;
		end
	end

	// clip rows
	w2s_dot #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .CLIP_W(CLIP_W)) u_dot_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_s1),
		.in_x(x_s1), .in_y(y_s1), .in_z(z_s1), .row_lo(xlo_q), .row_hi(xhi_q),
		.out_ctl(), .out_clip(cx)
	);

	w2s_dot #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .CLIP_W(CLIP_W)) u_dot_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_s1),
		.in_x(x_s1), .in_y(y_s1), .in_z(z_s1), .row_lo(ylo_q), .row_hi(yhi_q),
		.out_ctl(), .out_clip(cy)
	);

	w2s_dot #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .CLIP_W(CLIP_W)) u_dot_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_s1),
		.in_x(x_s1), .in_y(y_s1), .in_z(z_s1), .row_lo(wlo_q), .row_hi(whi_q),
		.out_ctl(ctl_nc), .out_clip(cw)
	);

	// visibility test and magnitudes for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= '{vld: ctl_nc.vld, vis: (cw >= WMIN_C)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s4 <= cx[CLIP_W-1];
			negy_s4 <= cy[CLIP_W-1];
			nx_s4   <= cx[CLIP_W-1] ? CLIP_W'(-cx) : CLIP_W'(cx);
			ny_s4   <= cy[CLIP_W-1] ? CLIP_W'(-cy) : CLIP_W'(cy);
			den_s4  <= CLIP_W'(cw);
		end
	end

	// ndc division, one lane per axis
	w2s_div #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_s4), .in_neg(negx_s4),
		.in_num(nx_s4), .in_den(den_s4), .out_ctl(ctl_d), .out_ndc(ndcx)
	);

	w2s_div #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_s4), .in_neg(negy_s4),
		.in_num(ny_s4), .in_den(den_s4), .out_ctl(), .out_ndc(ndcy)
	);

	// viewport and output registers
	w2s_view #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_view (
		.clk(clk), .arst_n(arst_n), .en(en), .in_ctl(ctl_d),
		.in_ndc_x(ndcx), .in_ndc_y(ndcy),
		.half_w(width_q[SIZE_W-1:1]), .half_h(height_q[SIZE_W-1:1]),
		.out_ctl(ctl_v), .out_x(screen_x), .out_y(screen_y)
	);

	assign screen_valid = ctl_v.vld;
	assign visible      = ctl_v.vis;

	// checks
	`W2S_ASSERT_NOW(a_hidden_zero, screen_valid && !visible,
		screen_x == '0 && screen_y == '0, "hidden point with nonzero screen position")
	`W2S_ASSERT_NOW(a_ndc_x_cap, ctl_d.vld && ctl_d.vis,
		ndcx <= CAP_P && ndcx >= -CAP_P, "ndc x beyond cap")
	`W2S_ASSERT_NOW(a_ndc_y_cap, ctl_d.vld && ctl_d.vis,
		ndcy <= CAP_P && ndcy >= -CAP_P, "ndc y beyond cap")
	`W2S_ASSERT_NEXT(a_hold_front, screen_valid && screen_stall,
		$stable(ctl_s1) && $stable(ctl_s4), "pipeline moved while output held")

endmodule

[sim/testbench.sv]
// testbench for the world to screen projection core: directed and random points
// checked against an in-bench projection predictor; depends on w2s_pkg and the core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import w2s_pkg::*;

	localparam int FB = DEF_FRAC_BITS;
	localparam int CB = DEF_COORD_BITS;
	localparam int LATENCY = 8 + CAP_LOG + 1;

	typedef struct packed {
		logic vis;
		logic signed [CB-1:0] sx;
		logic signed [CB-1:0] sy;
	} screen_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic point_valid = 1'b0;
	logic point_stall;
	logic signed [CB-1:0] world_x = '0, world_y = '0, world_z = '0;
	logic screen_valid;
	logic screen_stall = 1'b0;
	logic visible;
	logic signed [CB-1:0] screen_x, screen_y;

	// predictor copy of the registers
	logic [63:0] row_regs [6];
	logic [SIZE_W-1:0] vp_width, vp_height;

	screen_pt_t pending_pts[$];
	int mismatches = 0;
	bit stall_random = 1'b1;
	int stall_left = 0;

	world_to_screen_projection_core dut (.*);

	always #5 clk = ~clk;

	// helpers for the predictor
	function automatic longint floor_frac(longint v);
		return v >>> FB;
	endfunction

	function automatic longint row_product(logic [63:0] lo, logic [63:0] hi,
		longint x, longint y, longint z);
		longint a, b, c, d;
		a = longint'(signed'(lo[31:0]));
		b = longint'(signed'(lo[63:32]));
		c = longint'(signed'(hi[31:0]));
		d = longint'(signed'(hi[63:32]));
		return floor_frac(x * a) + floor_frac(y * b) + floor_frac(z * c) + d;
	endfunction

	function automatic longint ndc_divide(longint num, longint w);
		bit neg;
		logic [63:0] n, d, q, r;
		neg = num < 0;
		n = neg ? -num : num;
		d = w;
		q = n / d;
		r = n % d;
		for (int i = 0; i < FB; i++) begin
			if (q >= (64'd1 << CAP_LOG)) break;
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (q > (64'd1 << CAP_LOG)) q = 64'd1 << CAP_LOG;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [CB-1:0] clamp_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) << (CB - 1)) - 1;
		lo = -(longint'(1) << (CB - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[CB-1:0];
	endfunction

	function automatic screen_pt_t project_point(logic [CB-1:0] px, logic [CB-1:0] py,
		logic [CB-1:0] pz);
		screen_pt_t res;
		longint x, y, z, cx, cy, cw, hw, hh, w_min;
		x = longint'(signed'(px));
		y = longint'(signed'(py));
		z = longint'(signed'(pz));
		cx = row_product(row_regs[REG_X_LO], row_regs[REG_X_HI], x, y, z);
		cy = row_product(row_regs[REG_Y_LO], row_regs[REG_Y_HI], x, y, z);
		cw = row_product(row_regs[REG_W_LO], row_regs[REG_W_HI], x, y, z);
		w_min = ((longint'(1) << FB) + 9) / 10;
		res = '0;
		if (cw < w_min) return res;
		hw = vp_width / 2;
		hh = vp_height / 2;
		res.vis = 1'b1;
		res.sx = clamp_coord(hw * ndc_divide(cx, cw) + (hw << FB));
		res.sy = clamp_coord((hh << FB) - hh * ndc_divide(cy, cw));
		return res;
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// register write, setup then access, then idle
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < REG_WIDTH) row_regs[idx] = val;
		else if (idx == REG_WIDTH) vp_width = val[SIZE_W-1:0];
		else vp_height = val[SIZE_W-1:0];
		@(posedge clk);
	endtask

	// send one point request, optional gap before it; valid stays up for back to back
	task automatic send_point(logic [CB-1:0] px, logic [CB-1:0] py, logic [CB-1:0] pz,
		bit gaps);
		int gap;
		gap = gaps ? rand_gap() : 0;
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		world_x <= px;
		world_y <= py;
		world_z <= pz;
		pending_pts.push_back(project_point(px, py, pz));
		do @(posedge clk); while (point_stall);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		point_valid <= 1'b0;
		while (pending_pts.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word_pair();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7fff_ffff - $urandom_range(0, 3);
			default: return 32'(signed'($urandom_range(0, 200 << FB)) - (100 << FB));
		endcase
	endfunction

	// an identity-like perspective setup: w = z, so most points are visible
	task automatic load_perspective(logic [31:0] sxs, logic [31:0] sys);
		write_reg(REG_X_LO, {32'h0, sxs});
		write_reg(REG_X_HI, 64'h0);
		write_reg(REG_Y_LO, {sys, 32'h0});
		write_reg(REG_Y_HI, 64'h0);
		write_reg(REG_W_LO, 64'h0);
		write_reg(REG_W_HI, {32'h0, 32'h0001_0000});
	endtask

	// directed: extremes, threshold, degenerate sizes
	task automatic test_directed();
		int w_min;
		w_min = ((1 << FB) + 9) / 10;
		send_point('0, '0, '0, 0);
		drain();
		load_perspective(32'h0001_0000, 32'h0001_0000);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0);
		send_point(32'h0001_0000, 32'hffff_0000, 32'(w_min), 0);
		send_point(32'h0001_0000, 32'h0001_0000, 32'(w_min - 1), 0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'(w_min), 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_1000, 0);
		drain();
		write_reg(REG_WIDTH, 64'd1);
		write_reg(REG_HEIGHT, 64'd0);
		send_point(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 0);
		drain();
		write_reg(REG_WIDTH, 64'h7fff);
		write_reg(REG_HEIGHT, 64'hffff_ffff_ffff_ffff);
		send_point(32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 0);
		send_point(32'h7fff_0000, 32'h8000_0000, 32'h0001_0000, 0);
		drain();
		write_reg(REG_WIDTH, 64'd16384);
		write_reg(REG_HEIGHT, 64'd2);
		load_perspective(32'h7fff_ffff, 32'h8000_0000);
		write_reg(REG_X_HI, 64'h8000_0000_7fff_ffff);
		write_reg(REG_Y_HI, 64'h7fff_ffff_8000_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		drain();
	endtask

	// random points over several matrix and viewport settings
	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			stall_random = (phase != 2);
			if (phase < 3) begin
				load_perspective(32'($urandom_range(1 << 14, 4 << FB)),
					32'($urandom_range(1 << 14, 4 << FB)));
			end else begin
				for (int r = 0; r < 6; r++) write_reg(reg_idx_t'(r), rand_word_pair());
			end
			write_reg(REG_WIDTH, 64'($urandom_range(0, 32767)));
			write_reg(REG_HEIGHT, 64'($urandom_range(0, 32767)));
			for (int i = 0; i < 200; i++)
				send_point(rand_coord(), rand_coord(), rand_coord(), phase != 2);
			drain();
		end
	endtask

	// result stall pattern, runs mostly short and a few long
	always @(posedge clk) begin
		if (!stall_random) begin
			screen_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			screen_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) < 2) begin
			screen_stall <= 1'b1;
			stall_left <= rand_gap();
		end else begin
			screen_stall <= 1'b0;
		end
	end

	// compare each screen result with the oldest prediction
	always @(posedge clk) begin
		screen_pt_t exp_pt;
		if (arst_n && screen_valid && !screen_stall) begin
			if (pending_pts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0b %h %h",
					visible, screen_x, screen_y);
			end else begin
				exp_pt = pending_pts.pop_front();
				if (exp_pt.vis !== visible || exp_pt.sx !== screen_x
					|| exp_pt.sy !== screen_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0b %h %h got %0b %h %h",
							exp_pt.vis, exp_pt.sx, exp_pt.sy, visible, screen_x, screen_y);
				end
			end
		end
	end

	initial begin
		for (int r = 0; r < 6; r++) row_regs[r] = '0;
		vp_width = WIDTH_RST;
		vp_height = HEIGHT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (mismatches == 0 && pending_pts.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule
